### sv/mono_framebuffer_rotated_pixel_write_top_defines.svh
// Assertion macros shared by the framebuffer RTL.
// Each macro expects clk and rst_n in scope.
`ifndef MONO_FRAMEBUFFER_ROTATED_PIXEL_WRITE_TOP_DEFINES_SVH
`define MONO_FRAMEBUFFER_ROTATED_PIXEL_WRITE_TOP_DEFINES_SVH

// Same-cycle implication
`define MFBR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framebuffer check failed");

// Next-cycle implication
`define MFBR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framebuffer check failed");

`endif

### sv/mfbr_pkg.sv
package mfbr_pkg;

    // default panel geometry in pixels
    localparam int PANEL_WIDTH_DEF  = 880;
    localparam int PANEL_HEIGHT_DEF = 528;

    // operation codes carried in s_tuser
    localparam logic [1:0] MODE_PIXEL  = 2'd0;
    localparam logic [1:0] MODE_FILL   = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // fill byte for a white fill, inverted for black
    localparam logic [7:0] FILL_WHITE = 8'hFF;

    // leftmost pixel of a byte sits in the MSB
    localparam logic [7:0] MSB_MASK = 8'h80;

endpackage

### sv/mono_framebuffer_rotated_pixel_write_top.sv
// 1 bpp framebuffer of PANEL_WIDTH x PANEL_HEIGHT pixels held in one byte-wide synchronous
// RAM (one write and one registered read port), eight pixels a byte, leftmost pixel in the MSB.
// One item is handled at a time and every item returns exactly one result word. A pixel write
// is a read-modify-write of one byte in these steps: coordinate mapping, row multiply, address
// and RAM read, modify and write back, result; a point outside the logical area is dropped
// right after coordinate mapping. A byte read has a RAM read and a result step, and an unused
// mode goes straight to the result. A fill sweeps the RAM one byte a cycle, all of its
// PANEL_WIDTH*PANEL_HEIGHT/8 bytes (58080 by default); the input is stalled meanwhile. A new item
// is taken the cycle after the previous one has reached the output register, even if that
// result has not yet been taken; a stalled result holds the next one back.
// The RAM powers up undefined: fill it before reading. Rotation may only be written while idle.
`include "mono_framebuffer_rotated_pixel_write_top_defines.svh"

module mono_framebuffer_rotated_pixel_write_top #(
    parameter int PANEL_WIDTH  = mfbr_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = mfbr_pkg::PANEL_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: rotation in quarter turns
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // x_coord[15:0], y_coord[31:16], color[32],
                                  // read_index[48:33], zero[55:49]
    input  logic [1:0]  s_tuser,  // mode[1:0]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // read_data[7:0], dropped[8], zero[15:9]
);

    localparam int STORE_DEPTH = (PANEL_WIDTH * PANEL_HEIGHT) / 8;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int PX_W        = $clog2(PANEL_WIDTH);
    localparam int PY_W        = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
    localparam int PROD_W      = $clog2(PANEL_WIDTH * PANEL_HEIGHT);

    localparam logic [15:0]       W16       = 16'(PANEL_WIDTH);
    localparam logic [15:0]       H16       = 16'(PANEL_HEIGHT);
    localparam logic [PROD_W-1:0] DEPTH_P   = PROD_W'(STORE_DEPTH);
    localparam logic [ADDR_W-1:0] FILL_LAST = ADDR_W'(STORE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_MUL,
        S_ADDR,
        S_MODIFY,
        S_READ,
        S_FILL,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [1:0]          rotation_reg;
    logic                m_tvalid_reg;
    logic [15:0]         m_tdata_reg;

    // item payload
    logic [1:0]          mode_reg;
    logic [15:0]         x_reg;
    logic [15:0]         y_reg;
    logic                color_reg;
    logic [15:0]         rindex_reg;
    logic                rd_ok_reg;
    logic                drop_reg;
    logic [PX_W-1:0]     px_reg;
    logic [PY_W-1:0]     py_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   fill_cnt_reg;

    // frame RAM
    logic [7:0]          mem [STORE_DEPTH];
    logic [7:0]          mem_q;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [7:0]          mem_wdata;

    logic                in_acc;
    logic                out_free;
    logic                fill_end;
    logic [15:0]         lw;
    logic [15:0]         lh;
    logic                out_of_area;
    logic [15:0]         px16;
    logic [15:0]         py16;
    logic [PROD_W-1:0]   idx;
    logic                idx_ok;
    logic [7:0]          bit_mask;
    logic [7:0]          res_byte;
    logic                res_drop;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign fill_end  = (fill_cnt_reg == FILL_LAST);

    // logical bounds swap on quarter turns; unsigned compare also catches negatives
    assign lw          = rotation_reg[0] ? H16 : W16;
    assign lh          = rotation_reg[0] ? W16 : H16;
    assign out_of_area = (x_reg >= lw) || (y_reg >= lh);

    // map logical point to panel coordinates
    always_comb
    begin
        case (rotation_reg)
            2'd1:
            begin
                px16 = W16 - 16'd1 - y_reg;
                py16 = x_reg;
            end
            2'd2:
            begin
                px16 = W16 - 16'd1 - x_reg;
                py16 = H16 - 16'd1 - y_reg;
            end
            2'd3:
            begin
                px16 = y_reg;
                py16 = H16 - 16'd1 - x_reg;
            end
            default:
            begin
                px16 = x_reg;
                py16 = y_reg;
            end
        endcase
    end

    // byte index and bit within it
    assign idx      = PROD_W'(px_reg >> 3) + (prod_reg >> 3);
    assign idx_ok   = (idx < DEPTH_P);
    assign bit_mask = mfbr_pkg::MSB_MASK >> px_reg[2:0];

    // result fields
    assign res_byte = (mode_reg == mfbr_pkg::MODE_READ && rd_ok_reg) ? mem_q : 8'd0;
    assign res_drop = (mode_reg == mfbr_pkg::MODE_PIXEL) && drop_reg;

    // RAM port control
    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = addr_reg;
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = color_reg ? (mem_q | bit_mask) : (mem_q & ~bit_mask);
        case (state_reg)
            S_ADDR:
            begin
                mem_re    = idx_ok;
                mem_raddr = ADDR_W'(idx);
            end
            S_READ:
            begin
                mem_re    = rd_ok_reg;
                mem_raddr = ADDR_W'(rindex_reg);
            end
            S_MODIFY:
            begin
                mem_we = 1'b1;
            end
            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = fill_cnt_reg;
                mem_wdata = color_reg ? mfbr_pkg::FILL_WHITE : ~mfbr_pkg::FILL_WHITE;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    // frame RAM, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_raddr];
        end
    end

    // control: sequencer, rotation register, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rotation_reg <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                rotation_reg <= cfg_data;
            end
            // result valid: set as the result is registered, cleared once taken
            if (state_reg == S_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        unique case (s_tuser)
                            mfbr_pkg::MODE_PIXEL: state_reg <= S_MAP;
                            mfbr_pkg::MODE_FILL:  state_reg <= S_FILL;
                            mfbr_pkg::MODE_READ:  state_reg <= S_READ;
                            default:              state_reg <= S_DONE;
                        endcase
                    end
                end
                S_MAP:
                begin
                    state_reg <= out_of_area ? S_DONE : S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_ADDR;
                end
                S_ADDR:
                begin
                    state_reg <= idx_ok ? S_MODIFY : S_DONE;
                end
                S_MODIFY:
                begin
                    state_reg <= S_DONE;
                end
                S_READ:
                begin
                    state_reg <= S_DONE;
                end
                S_FILL:
                begin
                    if (fill_end)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            mode_reg     <= s_tuser;
            x_reg        <= s_tdata[15:0];
            y_reg        <= s_tdata[31:16];
            color_reg    <= s_tdata[32];
            rindex_reg   <= s_tdata[48:33];
            rd_ok_reg    <= (32'(s_tdata[48:33]) < 32'(STORE_DEPTH));
            drop_reg     <= 1'b0;
            fill_cnt_reg <= '0;
        end
        if (state_reg == S_MAP)
        begin
            drop_reg <= out_of_area;
            px_reg   <= PX_W'(px16);
            py_reg   <= PY_W'(py16);
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PROD_W'(py_reg) * PROD_W'(PANEL_WIDTH);
        end
        if (state_reg == S_ADDR)
        begin
            addr_reg <= ADDR_W'(idx);
        end
        if (state_reg == S_FILL)
        begin
            fill_cnt_reg <= fill_cnt_reg + ADDR_W'(1);
        end
        if (state_reg == S_DONE && out_free)
        begin
            m_tdata_reg <= {7'd0, res_drop, res_byte};
        end
    end

    // checks
    `MFBR_ASSERT_NEXT(a_one_item_at_a_time, s_tvalid && s_tready, !s_tready)
    `MFBR_ASSERT_NEXT(a_fill_completes, state_reg == S_FILL && !fill_end, state_reg == S_FILL)
    `MFBR_ASSERT_NEXT(a_result_held_back, state_reg == S_DONE && !out_free, state_reg == S_DONE)

endmodule

### tb/tb_mono_framebuffer_rotated_pixel_write_top.sv
`timescale 1ns / 100ps

module tb_mono_framebuffer_rotated_pixel_write_top;

    localparam int FB_W        = mfbr_pkg::PANEL_WIDTH_DEF;
    localparam int FB_H        = mfbr_pkg::PANEL_HEIGHT_DEF;
    localparam int FB_BYTES    = FB_W * FB_H / 8;
    localparam int IDLE_LIMIT  = 250000;
    localparam int PHASES      = 6;
    localparam int TAIL_CYCLES = 12;
    localparam int TOUCH_DEPTH = 32;

    typedef enum logic [1:0] {ROT_0, ROT_90, ROT_180, ROT_270} rot_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] x_coord;
        logic [15:0] y_coord;
        logic        color;
        logic [15:0] read_index;
    } fb_op_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       dropped;
    } fb_reply_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data  = 2'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = mfbr_pkg::MODE_PIXEL;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;

    // expected picture of the RAM and the rotation it was drawn with
    logic [7:0]  frame_img [0:FB_BYTES-1];
    rot_t        rot_model = ROT_0;

    fb_op_t      op_q [$];
    fb_reply_t   reply_q [$];
    int          touched_q [$];
    fb_op_t      op_on_bus;

    int          in_flight     = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          fills_left    = 4;
    int          err_count     = 0;
    int          stall_cycles  = 0;
    int          n_words_in    = 0;
    int          n_pixels      = 0;
    int          n_fills       = 0;
    int          n_reads       = 0;
    int          n_drops       = 0;
    int          n_results     = 0;

    rot_t        rot_plan [0:PHASES-1] = '{ROT_0, ROT_90, ROT_270, ROT_180, ROT_270, ROT_0};

    mono_framebuffer_rotated_pixel_write_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 clk = ~clk;

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // logical point to byte address and bit mask; 0 when outside the logical area
    function automatic bit pixel_locate(input rot_t rot, input int x, input int y,
                                        output int byte_ix, output logic [7:0] mask);
        int lw;
        int lh;
        int px;
        int py;
        lw      = rot[0] ? FB_H : FB_W;
        lh      = rot[0] ? FB_W : FB_H;
        byte_ix = 0;
        mask    = 8'h00;
        if (x < 0 || x >= lw || y < 0 || y >= lh)
            return 1'b0;
        case (rot)
            ROT_90:
            begin
                px = FB_W - 1 - y;
                py = x;
            end
            ROT_180:
            begin
                px = FB_W - 1 - x;
                py = FB_H - 1 - y;
            end
            ROT_270:
            begin
                px = y;
                py = FB_H - 1 - x;
            end
            default:
            begin
                px = x;
                py = y;
            end
        endcase
        byte_ix = px / 8 + (py * FB_W) / 8;
        mask    = mfbr_pkg::MSB_MASK >> (px % 8);
        return 1'b1;
    endfunction

    // apply one word to the picture and work out its result word
    function automatic fb_reply_t fb_apply_op(input fb_op_t op);
        fb_reply_t  r;
        int         bix;
        logic [7:0] m;
        r.read_data = 8'h00;
        r.dropped   = 1'b0;
        case (op.mode)
            mfbr_pkg::MODE_PIXEL:
            begin
                if (!pixel_locate(rot_model, $signed(op.x_coord), $signed(op.y_coord), bix, m))
                    r.dropped = 1'b1;
                else if (bix < FB_BYTES)
                    frame_img[bix] = op.color ? (frame_img[bix] | m) : (frame_img[bix] & ~m);
            end
            mfbr_pkg::MODE_FILL:
            begin
                for (int i = 0; i < FB_BYTES; i++)
                    frame_img[i] = op.color ? mfbr_pkg::FILL_WHITE : ~mfbr_pkg::FILL_WHITE;
            end
            mfbr_pkg::MODE_READ:
            begin
                if (op.read_index < FB_BYTES)
                    r.read_data = frame_img[op.read_index];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        err_count++;
    endtask

    task automatic queue_op(input logic [1:0] mode, input logic [15:0] x, input logic [15:0] y,
                            input logic color, input logic [15:0] ridx);
        fb_op_t op;
        op.mode       = mode;
        op.x_coord    = x;
        op.y_coord    = y;
        op.color      = color;
        op.read_index = ridx;
        op_q.push_back(op);
        in_flight++;
    endtask

    task automatic note_touched(input int bix);
        touched_q.push_back(bix);
        if (touched_q.size() > TOUCH_DEPTH)
            void'(touched_q.pop_front());
    endtask

    // random colour pixel, followed by a read of the byte it landed in when it lies inside the area
    task automatic queue_pixel_readback(input rot_t rot, input int x, input int y);
        int         bix;
        logic [7:0] m;
        queue_op(mfbr_pkg::MODE_PIXEL, 16'(x), 16'(y), 1'($urandom_range(0, 1)),
                 16'($urandom_range(0, 65535)));
        if (pixel_locate(rot, x, y, bix, m))
        begin
            note_touched(bix);
            queue_op(mfbr_pkg::MODE_READ, 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), 16'(bix));
        end
    endtask

    // random words for one rotation: draw-then-read pairs mixed with pixel writes, reads, fills and unused modes
    task automatic gen_phase(input rot_t rot, input int count);
        int         lw;
        int         lh;
        int         made;
        int         pick;
        int         bad;
        int         ok_val;
        int         bix;
        logic [7:0] m;
        lw   = rot[0] ? FB_H : FB_W;
        lh   = rot[0] ? FB_W : FB_H;
        made = 0;

        // corners of the logical area and just past them
        queue_pixel_readback(rot, 0, 0);
        queue_pixel_readback(rot, lw - 1, lh - 1);
        queue_pixel_readback(rot, 0, lh - 1);
        queue_pixel_readback(rot, lw - 1, 0);
        queue_pixel_readback(rot, lw, 0);
        queue_pixel_readback(rot, 0, lh);
        queue_pixel_readback(rot, -1, lh - 1);

        while (made < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick == 0 && fills_left > 0)
            begin
                fills_left--;
                queue_op(mfbr_pkg::MODE_FILL, 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                         16'($urandom_range(0, 65535)));
                made++;
            end
            else if (pick < 30)
            begin
                queue_pixel_readback(rot, $urandom_range(0, lw - 1), $urandom_range(0, lh - 1));
                made += 2;
            end
            else if (pick < 50)
            begin
                ok_val = $urandom_range(0, lw - 1);
                bad    = $urandom_range(0, lh - 1);
                if (pixel_locate(rot, ok_val, bad, bix, m))
                    note_touched(bix);
                queue_op(mfbr_pkg::MODE_PIXEL, 16'(ok_val), 16'(bad), 1'($urandom_range(0, 1)),
                         16'($urandom_range(0, 65535)));
                made++;
            end
            else if (pick < 62)
            begin
                // one axis outside, the other inside
                case ($urandom_range(0, 3))
                    0:       bad = -1;
                    1:       bad = 0;
                    2:       bad = -int'($urandom_range(1, 32768));
                    default: bad = 1;
                endcase
                if ($urandom_range(0, 1))
                begin
                    if (bad >= 0)
                        bad = (bad == 0) ? lw : $urandom_range(lw, 32767);
                    queue_op(mfbr_pkg::MODE_PIXEL, 16'(bad), 16'($urandom_range(0, lh - 1)),
                             1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
                end
                else
                begin
                    if (bad >= 0)
                        bad = (bad == 0) ? lh : $urandom_range(lh, 32767);
                    queue_op(mfbr_pkg::MODE_PIXEL, 16'($urandom_range(0, lw - 1)), 16'(bad),
                             1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
                end
                made++;
            end
            else if (pick < 70)
            begin
                queue_op(mfbr_pkg::MODE_PIXEL, 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                         16'($urandom_range(0, 65535)));
                made++;
            end
            else if (pick < 93)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5 && touched_q.size() != 0)
                    bix = touched_q[$urandom_range(0, touched_q.size() - 1)];
                else if (pick < 9)
                    bix = $urandom_range(0, FB_BYTES - 1);
                else
                    bix = $urandom_range(FB_BYTES, 65535);
                queue_op(mfbr_pkg::MODE_READ, 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), 16'(bix));
                made++;
            end
            else
            begin
                queue_op(mfbr_pkg::MODE_UNUSED, 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                         16'($urandom_range(0, 65535)));
                made++;
            end
        end
    endtask

    // rotation write, only issued with nothing in flight
    task automatic write_rotation(input rot_t rot);
        cfg_data  <= rot;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        rot_model = rot;
    endtask

    // input side: one word at a time from the pending queue
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= mfbr_pkg::MODE_PIXEL;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                reply_q.push_back(fb_apply_op(op_on_bus));
                n_words_in++;
                case (op_on_bus.mode)
                    mfbr_pkg::MODE_PIXEL: n_pixels++;
                    mfbr_pkg::MODE_FILL:  n_fills++;
                    mfbr_pkg::MODE_READ:  n_reads++;
                    default: ;
                endcase
            end
            if (!s_tvalid || s_tready)
            begin
                if (op_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    op_on_bus = op_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'd0, op_on_bus.read_index, op_on_bus.color,
                                 op_on_bus.y_coord, op_on_bus.x_coord};
                    s_tuser  <= op_on_bus.mode;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // output side: random back-pressure and field checks
    always @(posedge clk)
    begin
        fb_reply_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                n_results++;
                if (in_flight > 0)
                    in_flight--;
                if (reply_q.size() == 0)
                    report_mismatch($sformatf("result word %h with none expected", m_tdata));
                else
                begin
                    want = reply_q.pop_front();
                    if (want.dropped)
                        n_drops++;
                    if (m_tdata[7:0] !== want.read_data)
                        report_mismatch($sformatf("read_data %h, expected %h",
                                                  m_tdata[7:0], want.read_data));
                    if (m_tdata[8] !== want.dropped)
                        report_mismatch($sformatf("dropped %b, expected %b",
                                                  m_tdata[8], want.dropped));
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("tb_mono_framebuffer_rotated_pixel_write_top failed");
                $finish;
            end
        end
    end

    // phase sequencing
    initial
    begin
        int ph;
        wait (rst_n === 1'b1);
        @(posedge clk);
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph / 2)
                0:
                begin
                    send_idle_pct = 38;
                    recv_idle_pct = 76;
                end
                1:
                begin
                    send_idle_pct = 76;
                    recv_idle_pct = 38;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_rotation(rot_plan[ph]);
            if (ph == 0)
            begin
                // whole store defined first, then edges of the fields
                queue_op(mfbr_pkg::MODE_FILL, 16'h0000, 16'h0000, 1'b1, 16'h0000);
                queue_op(mfbr_pkg::MODE_READ, 16'hFFFF, 16'hFFFF, 1'b1, 16'd0);
                queue_op(mfbr_pkg::MODE_READ, 16'h0000, 16'h0000, 1'b0, 16'(FB_BYTES - 1));
                queue_op(mfbr_pkg::MODE_READ, 16'h0000, 16'h0000, 1'b0, 16'(FB_BYTES));
                queue_op(mfbr_pkg::MODE_READ, 16'h0000, 16'h0000, 1'b0, 16'hFFFF);
                queue_op(mfbr_pkg::MODE_PIXEL, 16'd0, 16'd0, 1'b0, 16'hFFFF);
                queue_op(mfbr_pkg::MODE_READ, 16'h0000, 16'h0000, 1'b0, 16'd0);
                queue_op(mfbr_pkg::MODE_PIXEL, 16'(FB_W - 1), 16'(FB_H - 1), 1'b0, 16'h0000);
                queue_op(mfbr_pkg::MODE_READ, 16'h0000, 16'h0000, 1'b0, 16'(FB_BYTES - 1));
                // points outside the area, then one inside and a read of its byte
                queue_op(mfbr_pkg::MODE_PIXEL, 16'hFFFF, 16'd0, 1'b1, 16'h0000);
                queue_op(mfbr_pkg::MODE_PIXEL, 16'd0, 16'h8000, 1'b1, 16'h0000);
                queue_op(mfbr_pkg::MODE_PIXEL, 16'(FB_W), 16'd0, 1'b1, 16'h0000);
                queue_op(mfbr_pkg::MODE_PIXEL, 16'd0, 16'(FB_H), 1'b1, 16'h0000);
                queue_op(mfbr_pkg::MODE_PIXEL, 16'h7FFF, 16'h7FFF, 1'b1, 16'h0000);
                queue_op(mfbr_pkg::MODE_PIXEL, 16'd0, 16'd0, 1'b1, 16'h0000);
                queue_op(mfbr_pkg::MODE_READ, 16'h0000, 16'h0000, 1'b0, 16'd0);
                // unused mode with every bit set
                queue_op(mfbr_pkg::MODE_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
                queue_op(mfbr_pkg::MODE_FILL, 16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF);
                queue_op(mfbr_pkg::MODE_READ, 16'h0000, 16'h0000, 1'b0, 16'd100);
                queue_op(mfbr_pkg::MODE_PIXEL, 16'd7, 16'd0, 1'b1, 16'h0000);
                queue_op(mfbr_pkg::MODE_PIXEL, 16'd8, 16'd1, 1'b1, 16'h0000);
                queue_op(mfbr_pkg::MODE_READ, 16'h0000, 16'h0000, 1'b0, 16'd0);
                queue_op(mfbr_pkg::MODE_READ, 16'h0000, 16'h0000, 1'b0, 16'(1 + FB_W / 8));
                queue_op(mfbr_pkg::MODE_READ, 16'h0000, 16'h0000, 1'b0, 16'h8000);
            end
            gen_phase(rot_plan[ph], (ph == 0) ? 90 : 94);
            // next rotation waits until every result is back
            while (in_flight != 0)
                @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (reply_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", reply_q.size()));
        $display("%0d words in: %0d pixel writes (%0d dropped), %0d fills, %0d byte reads",
                 n_words_in, n_pixels, n_drops, n_fills, n_reads);
        $display("%0d results checked over %0d rotation phases, %0d mismatches",
                 n_results, PHASES, err_count);
        if (err_count == 0)
            $display("tb_mono_framebuffer_rotated_pixel_write_top passed");
        else
            $display("tb_mono_framebuffer_rotated_pixel_write_top failed");
        $finish;
    end

endmodule

### mono_framebuffer_rotated_pixel_write_top.f
+incdir+sv
sv/mfbr_pkg.sv
sv/mono_framebuffer_rotated_pixel_write_top.sv
tb/tb_mono_framebuffer_rotated_pixel_write_top.sv
